// File: design/doy_cal_pkg.sv
// ----------------------------------------------------------------------------
// doy_cal_pkg
// Shared types and constants for the day-of-year to calendar field converter.
// ----------------------------------------------------------------------------
package doy_cal_pkg;

    localparam int YEAR_W   = 14;
    localparam int DAYS_W   = 16;
    localparam int MONTH_W  = 4;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 22;
    localparam int SEC_FRAC = 16;
    localparam int DOY_W    = 9;
    localparam int MDAY_W   = 5;
    localparam int NUM_MONTHS = 12;

    typedef logic [DOY_W-1:0]   t_doy;
    typedef logic [MONTH_W-1:0] t_month;

    // cumulative days before each month, entry 0 unused
    localparam t_doy CUM_DAYS [0:NUM_MONTHS] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    localparam logic [YEAR_W-1:0] YEAR_DURATION = '0;
    localparam logic [DAYS_W-1:0] LEN_COMMON    = 16'd365;
    localparam logic [DAYS_W-1:0] LEN_LEAP      = 16'd366;
    localparam logic [DAYS_W-1:0] DOY_FEB29     = 16'd59;
    localparam t_month            MONTH_NONE    = 4'd0;
    localparam t_month            MONTH_JAN     = 4'd1;
    localparam t_month            MONTH_FEB     = 4'd2;
    localparam t_month            MONTH_DEC     = 4'd12;
    localparam logic [MDAY_W-1:0] MDAY_FEB29    = 5'd29;
    localparam logic [MDAY_W-1:0] MDAY_LAST     = 5'd31;

    // year / 100 by reciprocal, exact for every 14-bit year
    localparam int                RECIP_SHIFT   = 19;
    localparam logic [12:0]       RECIP_100     = 13'd5243;
    localparam logic [6:0]        CENTURY       = 7'd100;

    function automatic logic year_is_leap(input logic [YEAR_W-1:0] y);
        logic [26:0]       prod;
        logic [7:0]        q;
        logic [YEAR_W-1:0] rem;
        prod = 27'(y) * 27'(RECIP_100);
        q    = prod[26:RECIP_SHIFT];
        rem  = y - (YEAR_W'(q) * YEAR_W'(CENTURY));
        if (rem == '0) begin
            return (q[1:0] == 2'b00);
        end
        return (y[1:0] == 2'b00);
    endfunction

endpackage

// File: design/day_of_year_to_calendar_fields.sv
// ----------------------------------------------------------------------------
// day_of_year_to_calendar_fields
// Converts year, zero-based day of year and a fixed-point day fraction into
// month, day of month, hour, minute and seconds (Q6.16).
// ----------------------------------------------------------------------------
// One item is taken per clock with start; busy is never raised. Each result
// appears on the outputs two cycles after the edge that takes its item, is
// held for one cycle under o_valid, and must be captured at the edge that
// ends that cycle: there is no back-pressure. The three register stages are
// the input register, a stage for the date lookup and the hour and minute
// products, and a stage for the seconds product. Year 0 gives a duration
// (month 0, day = whole days); a day past the year's end raises
// o_range_error and saturates to December 31.
module day_of_year_to_calendar_fields
    import doy_cal_pkg::*;
#(
    parameter int FRACTION_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [YEAR_W-1:0]        i_year,
    input  logic [DAYS_W-1:0]        i_whole_days,
    input  logic [FRACTION_BITS-1:0] i_day_fraction,
    output logic                     o_valid,
    output logic [YEAR_W-1:0]        o_year_out,
    output logic [MONTH_W-1:0]       o_month,
    output logic [DAYS_W-1:0]        o_day,
    output logic [HOUR_W-1:0]        o_hour,
    output logic [MINUTE_W-1:0]      o_minute,
    output logic [SECOND_W-1:0]      o_second_fixed,
    output logic                     o_range_error
);

    localparam int FB = FRACTION_BITS;

    // input register
    logic                  r_v0;
    logic [YEAR_W-1:0]     r_year0;
    logic [DAYS_W-1:0]     r_days0;
    logic [FB-1:0]         r_frac0;

    // middle stage
    logic                  r_v1;
    logic [YEAR_W-1:0]     r_year1;
    logic [MONTH_W-1:0]    r_month1;
    logic [DAYS_W-1:0]     r_day1;
    logic                  r_err1;
    logic [HOUR_W-1:0]     r_hour1;
    logic [MINUTE_W-1:0]   r_minute1;
    logic [FB-1:0]         r_frac1;

    // stage 0 logic
    logic                  n_leap;
    logic [MONTH_W-1:0]    n_month;
    logic [DAYS_W-1:0]     n_day;
    logic                  n_err;
    t_doy                  n_e;
    t_doy                  n_base;
    t_doy                  n_mday_full;
    logic [FB+4:0]         n_t1;
    logic [FB+5:0]         n_t2;
    logic [FB+5:0]         n_t3;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_v0    <= start;
            r_v1    <= r_v0;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_year0 <= i_year;
            r_days0 <= i_whole_days;
            r_frac0 <= i_day_fraction;
        end
        r_year1   <= r_year0;
        r_month1  <= n_month;
        r_day1    <= n_day;
        r_err1    <= n_err;
        r_hour1   <= n_t1[FB+4:FB];
        r_minute1 <= n_t2[FB+5:FB];
        r_frac1   <= n_t2[FB-1:0];
        o_year_out     <= r_year1;
        o_month        <= r_month1;
        o_day          <= r_day1;
        o_range_error  <= r_err1;
        o_hour         <= r_hour1;
        o_minute       <= r_minute1;
        o_second_fixed <= n_t3[FB+5:FB-SEC_FRAC];
    end

    // date lookup
    always_comb begin
        n_leap      = year_is_leap(r_year0);
        n_err       = 1'b0;
        n_month     = MONTH_JAN;
        n_base      = CUM_DAYS[1];
        n_e         = r_days0[DOY_W-1:0];
        if (n_leap && (r_days0 > DOY_FEB29)) begin
            n_e = r_days0[DOY_W-1:0] - t_doy'(1);
        end
        for (int k = 2; k <= NUM_MONTHS; k++) begin
            if (n_e >= CUM_DAYS[k]) begin
                n_month = MONTH_W'(k);
                n_base  = CUM_DAYS[k];
            end
        end
        n_mday_full = n_e - n_base + t_doy'(1);
        n_day       = DAYS_W'(n_mday_full[MDAY_W-1:0]);
        if (r_year0 == YEAR_DURATION) begin
            n_month = MONTH_NONE;
            n_day   = r_days0;
        end else if (r_days0 >= (n_leap ? LEN_LEAP : LEN_COMMON)) begin
            n_err   = 1'b1;
            n_month = MONTH_DEC;
            n_day   = DAYS_W'(MDAY_LAST);
        end else if (n_leap && (r_days0 == DOY_FEB29)) begin
            n_month = MONTH_FEB;
            n_day   = DAYS_W'(MDAY_FEB29);
        end
    end

    // time of day by constant products: 24 = 16 + 8, 60 = 64 - 4
    always_comb begin
        n_t1 = ((FB+5)'(r_frac0) << 4) + ((FB+5)'(r_frac0) << 3);
        n_t2 = ((FB+6)'(n_t1[FB-1:0]) << 6) - ((FB+6)'(n_t1[FB-1:0]) << 2);
        n_t3 = ((FB+6)'(r_frac1) << 6) - ((FB+6)'(r_frac1) << 2);
    end

`ifndef SYNTHESIS
    a_valid_follows_start: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 3)
    ) else $error("result without an accepted item");

    a_saturate: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_error) |-> (o_month == MONTH_DEC && o_day == 16'd31)
    ) else $error("range error without saturation");

    a_duration: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_year_out == YEAR_DURATION) |->
            (o_month == MONTH_NONE && !o_range_error)
    ) else $error("duration item with a month or error");

    a_date_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_year_out != YEAR_DURATION) |->
            (o_month >= MONTH_JAN && o_month <= MONTH_DEC &&
             o_day >= 16'd1 && o_day <= 16'd31)
    ) else $error("calendar date out of range");

    a_time_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour < 5'd24 && o_minute < 6'd60 && o_second_fixed[21:16] < 6'd60)
    ) else $error("time field out of range");
`endif

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for day_of_year_to_calendar_fields: directed dates,
// leap years, durations and days past year end, then random items with the
// sender idling at several rates, each result checked field by field.
// ----------------------------------------------------------------------------
module tb;
    import doy_cal_pkg::*;

    localparam int FRAC_W      = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 100;
    localparam int DRAIN_WAIT  = 8;

    localparam int unsigned MONTH_START [0:12] = '{
        0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAYS_W-1:0]   day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] seconds;
        logic                range_error;
    } t_cal_fields;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [YEAR_W-1:0]     i_year;
    logic [DAYS_W-1:0]     i_whole_days;
    logic [FRAC_W-1:0]     i_day_fraction;
    logic                  o_valid;
    logic [YEAR_W-1:0]     o_year_out;
    logic [MONTH_W-1:0]    o_month;
    logic [DAYS_W-1:0]     o_day;
    logic [HOUR_W-1:0]     o_hour;
    logic [MINUTE_W-1:0]   o_minute;
    logic [SECOND_W-1:0]   o_second_fixed;
    logic                  o_range_error;

    t_cal_fields pending_fields [$];
    int          n_errors   = 0;
    int          n_checked  = 0;
    int          n_dates    = 0;
    int          n_duration = 0;
    int          n_past_end = 0;
    int          cycle_count = 0;

    day_of_year_to_calendar_fields #(
        .FRACTION_BITS (FRAC_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_year         (i_year),
        .i_whole_days   (i_whole_days),
        .i_day_fraction (i_day_fraction),
        .o_valid        (o_valid),
        .o_year_out     (o_year_out),
        .o_month        (o_month),
        .o_day          (o_day),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second_fixed (o_second_fixed),
        .o_range_error  (o_range_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_leap_year(input logic [YEAR_W-1:0] y);
        int unsigned yv;
        yv = 32'(y);
        if (yv % 400 == 0) begin
            return 1'b1;
        end
        if (yv % 100 == 0) begin
            return 1'b0;
        end
        return (yv % 4 == 0);
    endfunction

    function automatic int unsigned year_length(input logic [YEAR_W-1:0] y);
        return is_leap_year(y) ? int'(LEN_LEAP) : int'(LEN_COMMON);
    endfunction

    function automatic t_cal_fields calendar_of(input logic [YEAR_W-1:0] y,
                                                input logic [DAYS_W-1:0] d,
                                                input logic [FRAC_W-1:0] f);
        logic [63:0] prod;
        bit          leap;
        int unsigned eff;
        int unsigned m;
        t_cal_fields r;
        prod      = 64'(f) * 64'd24;
        r.hour    = HOUR_W'(prod >> FRAC_W);
        prod      = 64'(prod[FRAC_W-1:0]) * 64'd60;
        r.minute  = MINUTE_W'(prod >> FRAC_W);
        prod      = 64'(prod[FRAC_W-1:0]) * 64'd60;
        r.seconds = SECOND_W'(prod >> (FRAC_W - SEC_FRAC));
        r.year        = y;
        r.range_error = 1'b0;
        if (y == YEAR_DURATION) begin
            r.month = MONTH_NONE;
            r.day   = d;
        end else begin
            leap = is_leap_year(y);
            if (d >= year_length(y)) begin
                r.range_error = 1'b1;
                r.month       = MONTH_DEC;
                r.day         = DAYS_W'(MDAY_LAST);
            end else if (leap && d == DOY_FEB29) begin
                r.month = MONTH_FEB;
                r.day   = DAYS_W'(MDAY_FEB29);
            end else begin
                eff = (leap && d > DOY_FEB29) ? d - 1 : d;
                m   = 12;
                while (m > 1 && eff < MONTH_START[m]) begin
                    m--;
                end
                r.month = MONTH_W'(m);
                r.day   = DAYS_W'(eff - MONTH_START[m] + 1);
            end
        end
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        if (n_errors < PRINT_LIMIT) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
        n_errors++;
    endtask

    task automatic send_date(input logic [YEAR_W-1:0] y,
                             input logic [DAYS_W-1:0] d,
                             input logic [FRAC_W-1:0] f);
        t_cal_fields want;
        logic        busy_seen;
        want = calendar_of(y, d, f);
        @(negedge i_clk);
        start          <= 1'b1;
        i_year         <= y;
        i_whole_days   <= d;
        i_day_fraction <= f;
        busy_seen = busy;
        @(posedge i_clk);
        while (busy_seen) begin
            @(negedge i_clk);
            busy_seen = busy;
            @(posedge i_clk);
        end
        pending_fields.push_back(want);
        if (want.range_error) begin
            n_past_end++;
        end else if (want.month == MONTH_NONE) begin
            n_duration++;
        end else begin
            n_dates++;
        end
    endtask

    task automatic sender_idle(input int pct);
        while ($urandom_range(99) < pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic pick_random_date(output logic [YEAR_W-1:0] y,
                                    output logic [DAYS_W-1:0] d,
                                    output logic [FRAC_W-1:0] f);
        int unsigned sel;
        int unsigned len;
        sel = $urandom_range(99);
        if (sel < 60) begin
            if ($urandom_range(3) == 0) begin
                y = YEAR_W'(4 * $urandom_range(1, 2499));
            end else begin
                y = YEAR_W'($urandom_range(1, 9999));
            end
            len = year_length(y);
            if ($urandom_range(4) == 0) begin
                d = DAYS_W'($urandom_range(57, 61));
            end else begin
                d = DAYS_W'($urandom_range(0, len - 1));
            end
        end else if (sel < 70) begin
            y = YEAR_DURATION;
            d = DAYS_W'($urandom);
        end else if (sel < 80) begin
            y   = YEAR_W'($urandom_range(1, 16383));
            len = year_length(y);
            if ($urandom_range(1) == 0) begin
                d = DAYS_W'($urandom_range(len, len + 2));
            end else begin
                d = DAYS_W'($urandom_range(len, 65535));
            end
        end else if (sel < 90) begin
            y = YEAR_W'($urandom_range(10000, 16383));
            d = DAYS_W'($urandom_range(0, year_length(y) - 1));
        end else begin
            y = YEAR_W'($urandom);
            d = DAYS_W'($urandom);
        end
        case ($urandom_range(7))
            0: f = '1 - FRAC_W'($urandom_range(3));
            1: f = FRAC_W'($urandom_range(3));
            default: f = FRAC_W'($urandom);
        endcase
    endtask

    task automatic test_month_boundaries;
        send_date(14'd2023, 16'd0, 32'd0);
        send_date(14'd2023, 16'd30, 32'd1);
        send_date(14'd2023, 16'd31, 32'h0AAA_AAAB);
        send_date(14'd2023, 16'd334, 32'h8000_0000);
        send_date(14'd2023, 16'd364, '1);
    endtask

    task automatic test_leap_rules;
        send_date(14'd2024, 16'd58, 32'h1234_5678);
        send_date(14'd2024, 16'd59, 32'hFFFF_0000);
        send_date(14'd2024, 16'd60, 32'h0000_FFFF);
        send_date(14'd2024, 16'd365, 32'h5555_5555);
        send_date(14'd1900, 16'd59, 32'hAAAA_AAAA);
        send_date(14'd2000, 16'd59, 32'h7FFF_FFFF);
        send_date(14'd16000, 16'd59, 32'hC000_0000);
        send_date(14'd16300, 16'd59, 32'h4000_0000);
    endtask

    task automatic test_durations;
        send_date(YEAR_DURATION, 16'd0, 32'd0);
        send_date(YEAR_DURATION, 16'hFFFF, '1);
        send_date(YEAR_DURATION, 16'd366, 32'h9E37_79B9);
    endtask

    task automatic test_range_errors;
        send_date(14'd2023, 16'd365, 32'h0000_0001);
        send_date(14'd2024, 16'd366, 32'hFFFF_FFFE);
        send_date(14'd1900, 16'd365, 32'h3333_3333);
        send_date(14'h3FFF, 16'hFFFF, '1);
        send_date(14'd9999, 16'd364, 32'hE000_0000);
        send_date(14'd1, 16'd0, 32'h0100_0000);
    endtask

    task automatic test_random_items(input int count, input int idle_pct);
        logic [YEAR_W-1:0] y;
        logic [DAYS_W-1:0] d;
        logic [FRAC_W-1:0] f;
        repeat (count) begin
            sender_idle(idle_pct);
            pick_random_date(y, d, f);
            send_date(y, d, f);
        end
    endtask

    always @(posedge i_clk) begin
        t_cal_fields want;
        if (i_rst_n && o_valid) begin
            if (pending_fields.size() == 0) begin
                report("unexpected result, year", 64'(o_year_out), '0);
            end else begin
                want = pending_fields.pop_front();
                n_checked++;
                if (o_year_out !== want.year) begin
                    report("year", 64'(o_year_out), 64'(want.year));
                end
                if (o_month !== want.month) begin
                    report("month", 64'(o_month), 64'(want.month));
                end
                if (o_day !== want.day) begin
                    report("day", 64'(o_day), 64'(want.day));
                end
                if (o_hour !== want.hour) begin
                    report("hour", 64'(o_hour), 64'(want.hour));
                end
                if (o_minute !== want.minute) begin
                    report("minute", 64'(o_minute), 64'(want.minute));
                end
                if (o_second_fixed !== want.seconds) begin
                    report("second_fixed", 64'(o_second_fixed), 64'(want.seconds));
                end
                if (o_range_error !== want.range_error) begin
                    report("range_error", 64'(o_range_error), 64'(want.range_error));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_fields.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_year         = '0;
        i_whole_days   = '0;
        i_day_fraction = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_month_boundaries();
        test_leap_rules();
        test_durations();
        test_range_errors();
        // back to back, then a slow sender, then an occasional gap
        test_random_items(300, 0);
        test_random_items(200, 88);
        test_random_items(400, 18);

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_fields.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("checked %0d results: %0d calendar dates, %0d durations, %0d past year end",
                 n_checked, n_dates, n_duration, n_past_end);
        $display("%0d field mismatches over %0d cycles", n_errors, cycle_count);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/doy_cal_pkg.sv
design/day_of_year_to_calendar_fields.sv
dv/tb.sv
